@@ hdl/mtt_pkg.sv @@
// shared constants for the min tournament tree update block
`timescale 1ns / 1ps
`default_nettype none

package mtt_pkg;

    // default tree shape
    localparam int MTT_LEAVES   = 1024;
    localparam int MTT_KEY_BITS = 32;

    // fixed port widths
    localparam int SLOT_BITS  = 10;
    localparam int VALUE_BITS = 32;

    // tie-break lfsr
    localparam int              LFSR_BITS = 16;
    localparam logic [LFSR_BITS-1:0] LFSR_SEED = 16'hACE1;

endpackage : mtt_pkg

`default_nettype wire

@@ hdl/mtt_ram.sv @@
// generic simple dual-port ram with registered read
`timescale 1ns / 1ps
`default_nettype none

module mtt_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule : mtt_ram

`default_nettype wire

@@ hdl/min_tournament_tree_update.sv @@
// top level of the min tournament tree update block
`timescale 1ns / 1ps
`default_nettype none

// min tournament tree over LEAVES slots, reporting the smallest key and its slot
//
// input channel: an item (slot, new_value) is taken at a rising edge with start
// high and busy low. new_value is cut or zero-extended to KEY_BITS and written to
// the leaf of slot; every ancestor up to the root is then recomputed, one level
// per cycle, through a read of the sibling and a write of the parent
// result channel: done is high for exactly one cycle with min_value and min_slot
// holding the root key and its slot; the receiver cannot stall, so results are
// never held back and nothing waits on the far side
// climb: after accept, node memory takes one read-modify-write per tree level
// and done follows the root write; busy drops in the done cycle, so the next
// item can be taken there
// a slot at or beyond LEAVES changes nothing and reports the current root in the
// cycle after accept
// reset: a clearing pass over every address fills both node memories with the
// empty marker (all ones) while busy is high; the lfsr loads its seed
// ties between equal keys are broken by bit 0 of a 16-bit lfsr, 1 picking right
module min_tournament_tree_update
    import mtt_pkg::*;
#(
    parameter int LEAVES   = MTT_LEAVES,
    parameter int KEY_BITS = MTT_KEY_BITS
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  start,
    output logic                       busy,
    input  wire logic [SLOT_BITS-1:0]  slot,
    input  wire logic [VALUE_BITS-1:0] new_value,
    output logic                       done,
    output logic      [VALUE_BITS-1:0] min_value,
    output logic      [SLOT_BITS-1:0]  min_slot
);

    localparam int SLOT_W = $clog2(LEAVES);
    localparam int NODE_W = KEY_BITS + SLOT_W;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_CLIMB
    } state_t;

    // slot carried by a leaf: its own number, except that the two end leaves both carry 0
    function automatic logic [SLOT_W-1:0] leaf_slot(input logic [SLOT_W-1:0] idx);
        logic [SLOT_W-1:0] res;
        if ((idx == '0) || (&idx))
        begin
            res = '0;
        end
        else
        begin
            res = idx;
        end
        return res;
    endfunction

    state_t               state_reg;
    logic [SLOT_W-1:0]    clr_cnt_reg;
    logic [SLOT_W-1:0]    node_reg;      // leaf offset on the first level, else internal node
    logic                 first_reg;     // sibling comes from the leaf memory
    logic [KEY_BITS-1:0]  cur_val_reg;
    logic [SLOT_W-1:0]    cur_slot_reg;
    logic [LFSR_BITS-1:0] lfsr_reg;
    logic [KEY_BITS-1:0]  root_val_reg;
    logic [SLOT_W-1:0]    root_slot_reg;
    logic                 done_reg;

    // input side
    logic                accept;
    logic                in_range;
    logic [SLOT_W-1:0]   slot_idx;
    logic [KEY_BITS-1:0] key_in;

    // climb datapath
    logic [KEY_BITS-1:0] sib_val;
    logic [SLOT_W-1:0]   sib_slot;
    logic [KEY_BITS-1:0] l_val;
    logic [KEY_BITS-1:0] r_val;
    logic [SLOT_W-1:0]   l_slot;
    logic [SLOT_W-1:0]   r_slot;
    logic                take_right;
    logic [KEY_BITS-1:0] win_val;
    logic [SLOT_W-1:0]   win_slot;
    logic [SLOT_W-1:0]   parent;
    logic                lfsr_fb;

    // memory ports
    logic                leaf_we;
    logic [SLOT_W-1:0]   leaf_waddr;
    logic [KEY_BITS-1:0] leaf_wdata;
    logic [SLOT_W-1:0]   leaf_raddr;
    logic [KEY_BITS-1:0] leaf_rdata;
    logic                node_we;
    logic [SLOT_W-1:0]   node_waddr;
    logic [NODE_W-1:0]   node_wdata;
    logic [SLOT_W-1:0]   node_raddr;
    logic [NODE_W-1:0]   node_rdata;

    assign busy     = (state_reg != ST_IDLE);
    assign accept   = start && (state_reg == ST_IDLE);
    assign in_range = (32'(slot) < 32'(LEAVES));
    assign slot_idx = SLOT_W'(slot);
    assign key_in   = KEY_BITS'(new_value);

    assign done      = done_reg;
    assign min_value = VALUE_BITS'(root_val_reg);
    assign min_slot  = SLOT_BITS'(root_slot_reg);

    // sibling of the node just updated: leaf memory on the first level
    assign sib_val  = first_reg ? leaf_rdata : node_rdata[NODE_W-1:SLOT_W];
    assign sib_slot = first_reg ? leaf_slot(node_reg ^ SLOT_W'(1)) : node_rdata[SLOT_W-1:0];

    // even node is the left child
    always_comb
    begin
        if (node_reg[0])
        begin
            l_val  = sib_val;
            l_slot = sib_slot;
            r_val  = cur_val_reg;
            r_slot = cur_slot_reg;
        end
        else
        begin
            l_val  = cur_val_reg;
            l_slot = cur_slot_reg;
            r_val  = sib_val;
            r_slot = sib_slot;
        end
    end

    assign take_right = (l_val > r_val) || ((l_val == r_val) && lfsr_reg[0]);
    assign win_val    = take_right ? r_val : l_val;
    assign win_slot   = take_right ? r_slot : l_slot;

    // parent of leaf s is LEAVES/2 + s/2, of internal node p is p/2
    assign parent  = {first_reg, node_reg[SLOT_W-1:1]};
    assign lfsr_fb = lfsr_reg[0] ^ lfsr_reg[2] ^ lfsr_reg[3] ^ lfsr_reg[5];

    // leaf memory: clearing pass, else the new key on accept of an in-range slot
    always_comb
    begin
        if (state_reg == ST_CLEAR)
        begin
            leaf_we    = 1'b1;
            leaf_waddr = clr_cnt_reg;
            leaf_wdata = '1;
        end
        else
        begin
            leaf_we    = accept && in_range;
            leaf_waddr = slot_idx;
            leaf_wdata = key_in;
        end
    end

    assign leaf_raddr = slot_idx ^ SLOT_W'(1);

    // internal node memory: clearing pass, else the parent of this level
    always_comb
    begin
        if (state_reg == ST_CLEAR)
        begin
            node_we    = 1'b1;
            node_waddr = clr_cnt_reg;
            node_wdata = {{KEY_BITS{1'b1}}, {SLOT_W{1'b0}}};
        end
        else
        begin
            node_we    = (state_reg == ST_CLIMB);
            node_waddr = parent;
            node_wdata = {win_val, win_slot};
        end
    end

    // sibling of the parent, used on the next level
    assign node_raddr = parent ^ SLOT_W'(1);

    mtt_ram #(
        .WIDTH (KEY_BITS),
        .DEPTH (LEAVES)
    ) u_leaf_ram (
        .clk   (clk),
        .we    (leaf_we),
        .waddr (leaf_waddr),
        .wdata (leaf_wdata),
        .raddr (leaf_raddr),
        .rdata (leaf_rdata)
    );

    mtt_ram #(
        .WIDTH (NODE_W),
        .DEPTH (LEAVES)
    ) u_node_ram (
        .clk   (clk),
        .we    (node_we),
        .waddr (node_waddr),
        .wdata (node_wdata),
        .raddr (node_raddr),
        .rdata (node_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            clr_cnt_reg   <= '0;
            node_reg      <= '0;
            first_reg     <= 1'b0;
            cur_val_reg   <= '0;
            cur_slot_reg  <= '0;
            lfsr_reg      <= LFSR_SEED;
            root_val_reg  <= '1;
            root_slot_reg <= '0;
            done_reg      <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            unique case (state_reg)
                ST_CLEAR:
                begin
                    clr_cnt_reg <= clr_cnt_reg + SLOT_W'(1);
                    if (&clr_cnt_reg)
                    begin
                        state_reg <= ST_IDLE;
                    end
                end
                ST_IDLE:
                begin
                    if (accept)
                    begin
                        if (in_range)
                        begin
                            node_reg     <= slot_idx;
                            first_reg    <= 1'b1;
                            cur_val_reg  <= key_in;
                            cur_slot_reg <= leaf_slot(slot_idx);
                            state_reg    <= ST_CLIMB;
                        end
                        else
                        begin
                            // nothing written, report the current root
                            done_reg <= 1'b1;
                        end
                    end
                end
                ST_CLIMB:
                begin
                    lfsr_reg     <= {lfsr_fb, lfsr_reg[LFSR_BITS-1:1]};
                    node_reg     <= parent;
                    first_reg    <= 1'b0;
                    cur_val_reg  <= win_val;
                    cur_slot_reg <= win_slot;
                    if (parent == SLOT_W'(1))
                    begin
                        root_val_reg  <= win_val;
                        root_slot_reg <= win_slot;
                        done_reg      <= 1'b1;
                        state_reg     <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

endmodule : min_tournament_tree_update

`default_nettype wire

@@ sim/min_tournament_tree_update_tb.sv @@
// self-checking testbench for the min tournament tree update block
`timescale 1ns / 1ps

module min_tournament_tree_update_tb;

    import mtt_pkg::*;

    localparam int LEAVES      = MTT_LEAVES;
    localparam int KEY_BITS    = MTT_KEY_BITS;
    localparam int NODES       = 2 * LEAVES;
    localparam int RANDOM_ITEMS = 1830;
    // clearing pass plus every item at its longest gap, taken several times over
    localparam int CYCLE_LIMIT = 400000;
    localparam int DRAIN_CYCLES = 20;

    // one pending leaf write
    typedef struct packed {
        logic [SLOT_BITS-1:0]  slot;
        logic [VALUE_BITS-1:0] key;
    } leaf_write_t;

    // root of the tree as reported after one item
    typedef struct packed {
        logic [VALUE_BITS-1:0] min_value;
        logic [SLOT_BITS-1:0]  min_slot;
    } root_result_t;

    logic                  clk       = 1'b0;
    logic                  rst_n     = 1'b0;
    logic                  start     = 1'b0;
    logic [SLOT_BITS-1:0]  slot      = '0;
    logic [VALUE_BITS-1:0] new_value = '0;
    logic                  busy;
    logic                  done;
    logic [VALUE_BITS-1:0] min_value;
    logic [SLOT_BITS-1:0]  min_slot;

    // own copy of the tree: key and owning slot per node, node 1 is the root
    logic [VALUE_BITS-1:0] node_key   [NODES];
    logic [SLOT_BITS-1:0]  node_owner [NODES];
    logic [LFSR_BITS-1:0]  tie_lfsr;

    leaf_write_t  pending_writes [$];
    root_result_t root_expected  [$];
    leaf_write_t  next_write;
    root_result_t seen_root;

    int unsigned burst_left = 1;
    int unsigned gap_left   = 0;
    int unsigned cycle_count = 0;
    int unsigned mismatches  = 0;

    min_tournament_tree_update #(
        .LEAVES   (LEAVES),
        .KEY_BITS (KEY_BITS)
    ) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .slot      (slot),
        .new_value (new_value),
        .done      (done),
        .min_value (min_value),
        .min_slot  (min_slot)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    task automatic report_mismatch(input string what);
        $display("%0t ns  mismatch: %s", $time, what);
        mismatches++;
    endtask

    // write one leaf, replay the path to the root and queue the root it leaves
    task automatic predict_root(input logic [SLOT_BITS-1:0]  leaf_slot,
                                input logic [VALUE_BITS-1:0] key);
        int unsigned  node;
        int unsigned  left_child;
        int unsigned  winner;
        logic         tie_bit;
        logic         feedback;
        logic         take_right;
        root_result_t root;
        // a slot beyond the tree changes nothing, lfsr included
        if (leaf_slot < LEAVES)
        begin
            // keys are full port width at the default key size
            node = LEAVES + leaf_slot;
            node_key[node] = key;
            node = node >> 1;
            while (node != 0)
            begin
                left_child = node * 2;
                tie_bit    = tie_lfsr[0];
                // fibonacci form, taps 16 14 13 11, steps at every level
                feedback   = tie_lfsr[0] ^ tie_lfsr[2] ^ tie_lfsr[3] ^ tie_lfsr[5];
                tie_lfsr   = {feedback, tie_lfsr[LFSR_BITS-1:1]};
                // right wins when strictly smaller, or on an exact tie with a 1
                take_right = (node_key[left_child] > node_key[left_child + 1]) ||
                             ((node_key[left_child] == node_key[left_child + 1]) &&
                              tie_bit);
                winner = take_right ? left_child + 1 : left_child;
                node_key[node]   = node_key[winner];
                node_owner[node] = node_owner[winner];
                node = node >> 1;
            end
        end
        root.min_value = node_key[1];
        root.min_slot  = node_owner[1];
        root_expected.push_back(root);
    endtask

    // driver: takes the next item off the pending queue, in bursts with gaps
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start      <= 1'b0;
            slot       <= '0;
            new_value  <= '0;
            burst_left <= $urandom_range(1, 12);
            gap_left   <= 0;
        end
        else
        begin
            if (start && !busy)
                predict_root(slot, new_value);

            if (start && busy)
            begin
                // item not taken yet, hold it steady
            end
            else if (gap_left != 0)
            begin
                start    <= 1'b0;
                gap_left <= gap_left - 1;
            end
            else if (pending_writes.size() != 0)
            begin
                next_write = pending_writes.pop_front();
                start     <= 1'b1;
                slot      <= next_write.slot;
                new_value <= next_write.key;
                if (burst_left <= 1)
                begin
                    burst_left <= $urandom_range(1, 12);
                    // a quarter of bursts run straight on, the rest pause
                    // for any phase of the block's update
                    gap_left   <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 30);
                end
                else
                    burst_left <= burst_left - 1;
            end
            else
                start <= 1'b0;
        end
    end

    // monitor: every done strobe is checked against the oldest expected root
    always @(posedge clk)
    begin
        if (rst_n && done)
        begin
            if (root_expected.size() == 0)
                report_mismatch($sformatf("result %0h/%0d with nothing outstanding",
                                          min_value, min_slot));
            else
            begin
                seen_root = root_expected.pop_front();
                if (min_value !== seen_root.min_value)
                    report_mismatch($sformatf("min_value %0h, predicted %0h",
                                              min_value, seen_root.min_value));
                if (min_slot !== seen_root.min_slot)
                    report_mismatch($sformatf("min_slot %0d, predicted %0d",
                                              min_slot, seen_root.min_slot));
            end
        end
    end

    // watchdog
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("timeout with %0d results outstanding", root_expected.size());
            $display("Simulation FAILED");
            $finish;
        end
    end

    // predictor reset, item list, run control
    initial
    begin
        leaf_write_t w;
        int unsigned hot_base;
        int unsigned pick;

        // reset image: all keys empty, leaves 1..LEAVES-2 own their slot
        for (int i = 0; i < NODES; i++)
        begin
            node_key[i]   = '1;
            node_owner[i] = '0;
        end
        for (int i = LEAVES + 1; i <= NODES - 2; i++)
            node_owner[i] = SLOT_BITS'(i - LEAVES);
        tie_lfsr = LFSR_SEED;

        // directed: outer slots, key extremes, ties between siblings and at the root
        pending_writes.push_back('{slot: 10'd0,    key: 32'h0000_0000});
        pending_writes.push_back('{slot: 10'd1023, key: 32'h0000_0000});
        pending_writes.push_back('{slot: 10'd1023, key: 32'hFFFF_FFFF});
        pending_writes.push_back('{slot: 10'd0,    key: 32'hFFFF_FFFF});
        pending_writes.push_back('{slot: 10'd1,    key: 32'd5});
        pending_writes.push_back('{slot: 10'd2,    key: 32'd5});
        pending_writes.push_back('{slot: 10'd3,    key: 32'd5});
        pending_writes.push_back('{slot: 10'd1022, key: 32'd5});
        pending_writes.push_back('{slot: 10'd512,  key: 32'd5});
        pending_writes.push_back('{slot: 10'd511,  key: 32'd4});
        pending_writes.push_back('{slot: 10'd511,  key: 32'hFFFF_FFFF});
        pending_writes.push_back('{slot: 10'd1,    key: 32'hFFFF_FFFF});
        pending_writes.push_back('{slot: 10'd5,    key: 32'h8000_0000});
        pending_writes.push_back('{slot: 10'd6,    key: 32'h7FFF_FFFF});
        pending_writes.push_back('{slot: 10'd1023, key: 32'hFFFF_FFFE});
        pending_writes.push_back('{slot: 10'd0,    key: 32'd1});
        pending_writes.push_back('{slot: 10'd0,    key: 32'd0});
        pending_writes.push_back('{slot: 10'd1023, key: 32'd0});
        pending_writes.push_back('{slot: 10'd682,  key: 32'h5555_5555});
        pending_writes.push_back('{slot: 10'd341,  key: 32'hAAAA_AAAA});
        pending_writes.push_back('{slot: 10'd1022, key: 32'hFFFF_FFFF});

        // random: half the writes land in a small hot group of neighbouring
        // leaves with few distinct keys, so the current minimum keeps being
        // overwritten and ties come up at every level
        hot_base = $urandom_range(0, LEAVES / 8 - 1) * 8;
        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            if (n % 100 == 99)
                hot_base = $urandom_range(0, LEAVES / 8 - 1) * 8;
            pick = $urandom_range(0, 5);
            if (pick <= 2)
                w.slot = SLOT_BITS'(hot_base + $urandom_range(0, 7));
            else if (pick == 3)
                w.slot = SLOT_BITS'(($urandom_range(0, 1) == 0) ? $urandom_range(0, 1)
                                                              : $urandom_range(1022, 1023));
            else
                w.slot = SLOT_BITS'($urandom_range(0, LEAVES - 1));
            pick = $urandom_range(0, 7);
            if (pick <= 2)
                w.key = $urandom_range(0, 3);
            else if (pick == 3)
                w.key = '1;
            else if (pick == 4)
                w.key = $urandom_range(32'hFFFF_FFF0, 32'hFFFF_FFFF);
            else
                w.key = $urandom;
            pending_writes.push_back(w);
        end

        // single reset at the start, released on a clock edge
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        // every item handed over, then every result back, then a quiet tail
        @(posedge clk);
        while (pending_writes.size() != 0 || start)
            @(posedge clk);
        while (root_expected.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (mismatches == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
